FILE: hw/rtl/jhds_pkg.sv
// ----------------------------------------------------------------------------
// JPEG header dimension scanner - shared definitions
// Parse phases, result reason codes, marker constants and the result record
// passed from the parser to the output stage.
// ----------------------------------------------------------------------------
package jhds_pkg;

   // Parse phase of the byte walker
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SOI  = 3'd1,
      PH_HDR  = 3'd2,
      PH_SKIP = 3'd3,
      PH_SOF  = 3'd4
   } phase_type;

   // Outcome codes carried in the result beat
   typedef enum logic [2:0] {
      RS_OK      = 3'd0,
      RS_NO_SOI  = 3'd1,
      RS_NO_FF   = 3'd2,
      RS_UNSUP   = 3'd3,
      RS_EARLY   = 3'd4,
      RS_BAD_LEN = 3'd5
   } reason_type;

   localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
   localparam logic [7:0]  SOI_CODE      = 8'hD8;
   localparam logic [7:0]  SOF0_CODE     = 8'hC0;
   localparam logic [15:0] MIN_SEG_LEN   = 16'd2;

   // Result of one step, valid when the outcome of the file is known
   typedef struct packed {
      logic        valid;
      logic        ok;
      reason_type  reason;
      logic [15:0] width;
      logic [15:0] height;
   } scan_result_type;

   // SOF codes other than baseline: C1-C3, C5-C7, C9-CB, CD-CF
   function automatic logic is_other_sof(input logic [7:0] code);
      logic in_range;
      in_range = (code >= 8'hC1) && (code <= 8'hCF);
      return in_range && (code != 8'hC4) && (code != 8'hC8) && (code != 8'hCC);
   endfunction

endpackage

FILE: hw/rtl/jhds_parser.sv
// ----------------------------------------------------------------------------
// JPEG header dimension scanner - byte parser
// Holds the parse state and works out, for one byte, the next state and
// whether the file's result is decided on it.
// ----------------------------------------------------------------------------
module jhds_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,     // consume the byte this cycle
   input  logic [7:0]                data_byte,
   input  logic                      first_byte,
   input  logic                      last_byte,
   output jhds_pkg::scan_result_type result
);

   jhds_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          index_ff, index_in;
   logic [7:0]          marker_ff, marker_in;
   logic [7:0]          len_high_ff, len_high_in;
   logic [15:0]         skip_ff, skip_in;
   logic [7:0]          height_hi_ff, height_hi_in;
   logic [7:0]          height_lo_ff, height_lo_in;
   logic [7:0]          width_hi_ff, width_hi_in;

   jhds_pkg::phase_type phase_cur;
   logic [2:0]          index_cur;
   logic [15:0]         seg_len;
   logic                decide;
   jhds_pkg::reason_type reason;

   // Next state and result for the presented byte
   always_comb begin
      phase_in     = phase_ff;
      index_in     = index_ff;
      marker_in    = marker_ff;
      len_high_in  = len_high_ff;
      skip_in      = skip_ff;
      height_hi_in = height_hi_ff;
      height_lo_in = height_lo_ff;
      width_hi_in  = width_hi_ff;
      decide       = 1'b0;
      reason       = jhds_pkg::RS_OK;
      seg_len      = {len_high_ff, data_byte};

      // a first byte restarts the parse at the start-of-image word
      phase_cur = first_byte ? jhds_pkg::PH_SOI : phase_ff;
      index_cur = first_byte ? 3'd0 : index_ff;
      phase_in  = phase_cur;
      index_in  = index_cur;

      unique case (phase_cur)
         jhds_pkg::PH_SOI: begin
            if (index_cur == 3'd0) begin
               if (data_byte != jhds_pkg::MARKER_PREFIX) begin
                  decide = 1'b1;
                  reason = jhds_pkg::RS_NO_SOI;
               end else begin
                  index_in = 3'd1;
               end
            end else if (data_byte != jhds_pkg::SOI_CODE) begin
               decide = 1'b1;
               reason = jhds_pkg::RS_NO_SOI;
            end else begin
               phase_in = jhds_pkg::PH_HDR;
               index_in = 3'd0;
            end
         end
         jhds_pkg::PH_HDR: begin
            case (index_cur)
               3'd0: begin
                  if (data_byte != jhds_pkg::MARKER_PREFIX) begin
                     decide = 1'b1;
                     reason = jhds_pkg::RS_NO_FF;
                  end else begin
                     index_in = 3'd1;
                  end
               end
               3'd1: begin
                  marker_in = data_byte;
                  index_in  = 3'd2;
               end
               3'd2: begin
                  len_high_in = data_byte;
                  index_in    = 3'd3;
               end
               default: begin
                  // length low byte: header complete
                  index_in = 3'd0;
                  if (marker_ff == jhds_pkg::SOF0_CODE) begin
                     phase_in = jhds_pkg::PH_SOF;
                  end else if (jhds_pkg::is_other_sof(marker_ff)) begin
                     decide = 1'b1;
                     reason = jhds_pkg::RS_UNSUP;
                  end else if (seg_len < jhds_pkg::MIN_SEG_LEN) begin
                     decide = 1'b1;
                     reason = jhds_pkg::RS_BAD_LEN;
                  end else begin
                     skip_in  = seg_len - jhds_pkg::MIN_SEG_LEN;
                     phase_in = (seg_len == jhds_pkg::MIN_SEG_LEN) ?
                                jhds_pkg::PH_HDR : jhds_pkg::PH_SKIP;
                  end
               end
            endcase
         end
         jhds_pkg::PH_SKIP: begin
            skip_in = skip_ff - 16'd1;
            if (skip_ff == 16'd1) begin
               phase_in = jhds_pkg::PH_HDR;
               index_in = 3'd0;
            end
         end
         jhds_pkg::PH_SOF: begin
            // precision byte, then height and width big-endian
            case (index_cur)
               3'd1:    height_hi_in = data_byte;
               3'd2:    height_lo_in = data_byte;
               3'd3:    width_hi_in  = data_byte;
               3'd4: begin
                  decide = 1'b1;
                  reason = jhds_pkg::RS_OK;
               end
               default: ;
            endcase
            index_in = index_cur + 3'd1;
         end
         default: ;
      endcase

      // file ends before the outcome is known
      if ((phase_cur != jhds_pkg::PH_IDLE) && !decide && last_byte) begin
         decide = 1'b1;
         reason = jhds_pkg::RS_EARLY;
      end

      if (decide) begin
         phase_in = jhds_pkg::PH_IDLE;
         index_in = 3'd0;
      end

      result.valid  = decide;
      result.ok     = decide && (reason == jhds_pkg::RS_OK);
      result.reason = reason;
      result.width  = result.ok ? {width_hi_ff, data_byte} : 16'd0;
      result.height = result.ok ? {height_hi_ff, height_lo_ff} : 16'd0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jhds_pkg::PH_IDLE;
         index_ff <= 3'd0;
         skip_ff  <= 16'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         skip_ff  <= skip_in;
      end
   end

   // Header and dimension bytes, always written before use
   always_ff @(posedge clock) begin
      if (step_en) begin
         marker_ff    <= marker_in;
         len_high_ff  <= len_high_in;
         height_hi_ff <= height_hi_in;
         height_lo_ff <= height_lo_in;
         width_hi_ff  <= width_hi_in;
      end
   end

endmodule

FILE: hw/rtl/jpeg_header_dimension_scanner.sv
// ----------------------------------------------------------------------------
// JPEG header dimension scanner
// Walks a JPEG byte stream and reports the baseline frame size or the reason
// the file could not be used.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one file byte per beat; req_tuser marks the first
//   byte of a file (restarts the parse), req_tlast its final byte. The rsp_
//   channel gives at most one beat per file, on the byte where the outcome
//   becomes known: ok in rsp_tuser, reason code and dimensions in rsp_tdata.
//   Bytes outside an open file are dropped without a result.
//   The deciding byte is held in the input register and its outcome is clocked
//   into the result register, which drives rsp_tvalid.
//   Throughput: one byte per cycle while no stalled result beat blocks the
//   parse; the per-byte state update is one short step between the input
//   register and the result register.
//   A stalled result beat holds in the result register; the parse keeps
//   taking bytes that give no result, and stops only when a further result
//   would need the occupied register.
//   Reset empties both registers and returns the parser to idle, waiting for
//   a byte with req_tuser set.
// ----------------------------------------------------------------------------
module jpeg_header_dimension_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] reason, [18:3] image_width,
                                    // [34:19] image_height, [39:35] zero
   output logic        rsp_tuser    // [0] ok
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_first_ff;
   logic                      in_last_ff;
   logic                      out_valid_ff, out_valid_in;
   jhds_pkg::scan_result_type out_ff;
   jhds_pkg::scan_result_type result;
   logic                      advance;
   logic                      load_out;

   // Parse step on the registered byte
   jhds_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .last_byte  (in_last_ff),
      .result     (result)
   );

   // Byte moves on unless it carries a result that cannot be stored
   always_comb begin
      advance      = in_valid_ff && (!result.valid || !out_valid_ff || rsp_tready);
      load_out     = advance && result.valid;
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = load_out || (out_valid_ff && !rsp_tready);
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.ok;
   assign rsp_tdata  = {5'd0, out_ff.height, out_ff.width, out_ff.reason};

   // ok flag agrees with the reason code
   a_ok_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (out_ff.reason == jhds_pkg::RS_OK)))
      else $error("ok flag disagrees with reason code");

   // failed files report zero dimensions
   a_zero_dims_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[34:3] == 32'd0))
      else $error("dimensions reported for a failed file");

   // a pending result beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(load_out && out_valid_ff && !rsp_tready))
      else $error("result register overwritten while stalled");

   // reset empties both registers
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !in_valid_ff))
      else $error("registers not empty after reset");

endmodule

FILE: tb/jpeg_header_dimension_scanner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG header dimension scanner - testbench
// Streams whole and broken JPEG headers into the scanner one byte per beat,
// predicts the outcome of every file on the side and checks each result beat
// against it in order. Both channels idle at random, and the result side
// holds off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module jpeg_header_dimension_scanner_test;

   localparam int RANDOM_BEATS   = 550;
   localparam int HOLDOFF_AT     = 150;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // Marker codes used by the stimulus and the frame check
   localparam logic [7:0] EOI_CODE      = 8'hD9;
   localparam logic [7:0] APP0_CODE     = 8'hE0;
   localparam logic [7:0] SOF2_CODE     = 8'hC2;
   localparam logic [7:0] FRAME_FIRST   = 8'hC1;
   localparam logic [7:0] FRAME_LAST    = 8'hCF;
   localparam logic [7:0] DHT_CODE      = 8'hC4;
   localparam logic [7:0] JPG_CODE      = 8'hC8;
   localparam logic [7:0] DAC_CODE      = 8'hCC;
   localparam logic [7:0] PRECISION_8   = 8'h08;

   // One input beat: file byte plus its framing flags
   typedef struct packed {
      logic [7:0] data;
      logic       is_first;
      logic       is_last;
   } file_beat_type;

   // One predicted file outcome
   typedef struct packed {
      logic                 ok;
      jhds_pkg::reason_type reason;
      logic [15:0]          width;
      logic [15:0]          height;
   } file_outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tuser  = 1'b0;    // [0] first_byte
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [2:0] reason, [18:3] width, [34:19] height
   logic        rsp_tuser;            // [0] ok

   file_beat_type    pending_beats[$];
   file_outcome_type expected_outcomes[$];
   logic [7:0]       file_build[$];

   int beats_taken   = 0;
   int total_beats   = 0;
   int fail_count    = 0;
   int feed_gap      = 0;
   int sink_gap      = 0;
   int holdoff_left  = 0;
   int idle_cycles   = 0;
   logic holdoff_done = 1'b0;
   logic feed_steady  = 1'b0;
   logic sink_steady  = 1'b0;

   // Predictor state
   jhds_pkg::phase_type scan_phase = jhds_pkg::PH_IDLE;
   logic [2:0]          hdr_pos    = 3'd0;
   logic [7:0]          seen_code  = 8'h00;
   logic [7:0]          len_hi     = 8'h00;
   logic [15:0]         skip_left  = 16'd0;
   logic [15:0]         height_acc = 16'd0;
   logic [15:0]         width_acc  = 16'd0;

   jpeg_header_dimension_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Frame codes other than baseline, which the scanner refuses
   function automatic logic frame_code_unsupported(input logic [7:0] code);
      return (code >= FRAME_FIRST) && (code <= FRAME_LAST) &&
             (code != DHT_CODE) && (code != JPG_CODE) && (code != DAC_CODE);
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advance the predicted parse by one accepted byte
   task automatic predict_byte(input logic [7:0] b, input logic first, input logic last);
      logic                 decided_now;
      jhds_pkg::reason_type why;
      logic [15:0]          seg_len;
      decided_now = 1'b0;
      why         = jhds_pkg::RS_OK;
      seg_len     = {len_hi, b};
      if (first) begin
         scan_phase = jhds_pkg::PH_SOI;
         hdr_pos    = 3'd0;
         seen_code  = 8'h00;
         len_hi     = 8'h00;
         skip_left  = 16'd0;
         height_acc = 16'd0;
         width_acc  = 16'd0;
      end
      if (scan_phase != jhds_pkg::PH_IDLE) begin
         case (scan_phase)
            jhds_pkg::PH_SOI: begin
               if (b != ((hdr_pos == 3'd0) ? jhds_pkg::MARKER_PREFIX
                                           : jhds_pkg::SOI_CODE)) begin
                  decided_now = 1'b1;
                  why         = jhds_pkg::RS_NO_SOI;
               end else if (hdr_pos == 3'd0) begin
                  hdr_pos = 3'd1;
               end else begin
                  scan_phase = jhds_pkg::PH_HDR;
                  hdr_pos    = 3'd0;
               end
            end
            jhds_pkg::PH_HDR: begin
               case (hdr_pos)
                  3'd0: begin
                     if (b != jhds_pkg::MARKER_PREFIX) begin
                        decided_now = 1'b1;
                        why         = jhds_pkg::RS_NO_FF;
                     end else begin
                        hdr_pos = 3'd1;
                     end
                  end
                  3'd1: begin
                     seen_code = b;
                     hdr_pos   = 3'd2;
                  end
                  3'd2: begin
                     len_hi  = b;
                     hdr_pos = 3'd3;
                  end
                  default: begin
                     hdr_pos = 3'd0;
                     if (seen_code == jhds_pkg::SOF0_CODE) begin
                        scan_phase = jhds_pkg::PH_SOF;
                     end else if (frame_code_unsupported(seen_code)) begin
                        decided_now = 1'b1;
                        why         = jhds_pkg::RS_UNSUP;
                     end else if (seg_len < jhds_pkg::MIN_SEG_LEN) begin
                        decided_now = 1'b1;
                        why         = jhds_pkg::RS_BAD_LEN;
                     end else begin
                        skip_left  = seg_len - jhds_pkg::MIN_SEG_LEN;
                        scan_phase = (skip_left == 16'd0) ? jhds_pkg::PH_HDR
                                                          : jhds_pkg::PH_SKIP;
                     end
                  end
               endcase
            end
            jhds_pkg::PH_SKIP: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 16'd0) begin
                  scan_phase = jhds_pkg::PH_HDR;
                  hdr_pos    = 3'd0;
               end
            end
            default: begin
               // precision byte at position 0, then height and width big-endian
               case (hdr_pos)
                  3'd1: height_acc = {b, 8'h00};
                  3'd2: height_acc[7:0] = b;
                  3'd3: width_acc = {b, 8'h00};
                  3'd4: begin
                     width_acc[7:0] = b;
                     decided_now    = 1'b1;
                     why            = jhds_pkg::RS_OK;
                  end
                  default: ;
               endcase
               if (!decided_now) hdr_pos = hdr_pos + 3'd1;
            end
         endcase
         // early end only when this byte did not settle the file itself
         if (!decided_now && last) begin
            decided_now = 1'b1;
            why         = jhds_pkg::RS_EARLY;
         end
         if (decided_now) begin
            expected_outcomes.push_back('{ok: (why == jhds_pkg::RS_OK), reason: why,
               width: (why == jhds_pkg::RS_OK) ? width_acc : 16'd0,
               height: (why == jhds_pkg::RS_OK) ? height_acc : 16'd0});
            scan_phase = jhds_pkg::PH_IDLE;
            hdr_pos    = 3'd0;
         end
      end
   endtask

   task automatic add_byte(input logic [7:0] b);
      file_build.push_back(b);
   endtask

   task automatic add_header(input logic [7:0] code, input logic [15:0] seg_len);
      add_byte(jhds_pkg::MARKER_PREFIX);
      add_byte(code);
      add_byte(seg_len[15:8]);
      add_byte(seg_len[7:0]);
   endtask

   // Queue the file being built, first flag on its head and last on its tail
   task automatic emit_file();
      for (int i = 0; i < file_build.size(); i++)
         pending_beats.push_back('{data: file_build[i], is_first: (i == 0),
                                   is_last: (i == file_build.size() - 1)});
      file_build.delete();
   endtask

   // Input driver
   always @(posedge clock) begin : feed
      file_beat_type nb;
      if (reset) begin
         req_tvalid <= 1'b0;
         feed_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_byte(req_tdata, req_tuser, req_tlast);
            beats_taken <= beats_taken + 1;
            if ($urandom_range(0, 79) == 0) feed_steady <= !feed_steady;
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered beat
         end else if (feed_gap != 0) begin
            feed_gap   <= feed_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            nb = pending_beats.pop_front();
            req_tdata  <= nb.data;
            req_tuser  <= nb.is_first;
            req_tlast  <= nb.is_last;
            req_tvalid <= 1'b1;
            feed_gap   <= feed_steady ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // One long receiver hold-off once traffic is under way
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holdoff_done <= 1'b0;
      end else if (!holdoff_done && beats_taken == HOLDOFF_AT) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Result monitor and checker
   always @(posedge clock) begin : sink
      file_outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("unexpected result beat: ok=%0d tdata=%h", rsp_tuser, rsp_tdata);
               fail_count = fail_count + 1;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tuser !== want.ok || rsp_tdata[2:0] !== want.reason ||
                   rsp_tdata[18:3] !== want.width || rsp_tdata[34:19] !== want.height ||
                   rsp_tdata[39:35] !== 5'd0) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"result mismatch: exp ok=%0d reason=%0d w=%0d h=%0d, ",
                               "got ok=%0d reason=%0d w=%0d h=%0d pad=%0d"},
                              want.ok, want.reason, want.width, want.height, rsp_tuser,
                              rsp_tdata[2:0], rsp_tdata[18:3], rsp_tdata[34:19],
                              rsp_tdata[39:35]);
                  fail_count = fail_count + 1;
               end
            end
            if ($urandom_range(0, 15) == 0) sink_steady <= !sink_steady;
         end
         if (sink_gap != 0) begin
            sink_gap   <= sink_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (holdoff_left == 0);
            sink_gap   <= sink_steady ? 0 : pick_gap();
         end
      end
   end

   // Watchdog on cycles with no beat accepted on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("jpeg_header_dimension_scanner_test: done, errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int          kind;
      int          nseg;
      int          seg_len;
      int          cut;
      logic [7:0]  code;
      logic [15:0] dim;

      // bytes with no file open are dropped
      pending_beats.push_back('{data: 8'h00, is_first: 1'b0, is_last: 1'b0});
      pending_beats.push_back('{data: jhds_pkg::MARKER_PREFIX, is_first: 1'b0,
                                is_last: 1'b1});
      // empty segment, then baseline frame at the largest size, ending on its last byte
      add_byte(jhds_pkg::MARKER_PREFIX); add_byte(jhds_pkg::SOI_CODE);
      add_header(EOI_CODE, jhds_pkg::MIN_SEG_LEN);
      add_header(jhds_pkg::SOF0_CODE, 16'd17);
      add_byte(PRECISION_8);
      repeat (4) add_byte(8'hFF);
      emit_file();
      // wrong start word on a one-byte file
      add_byte(8'h00);
      emit_file();
      // file that ends inside the start word
      add_byte(jhds_pkg::MARKER_PREFIX);
      emit_file();
      // header without its prefix
      add_byte(jhds_pkg::MARKER_PREFIX); add_byte(jhds_pkg::SOI_CODE); add_byte(8'h00);
      emit_file();
      // progressive frame
      add_byte(jhds_pkg::MARKER_PREFIX); add_byte(jhds_pkg::SOI_CODE);
      add_header(SOF2_CODE, 16'd0);
      emit_file();
      // segment length below two
      add_byte(jhds_pkg::MARKER_PREFIX); add_byte(jhds_pkg::SOI_CODE);
      add_header(APP0_CODE, 16'd1);
      emit_file();

      // random files, mostly well formed
      while (pending_beats.size() < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) == 0) begin
            // line noise with random framing
            repeat ($urandom_range(1, 5))
               pending_beats.push_back('{data: 8'($urandom_range(0, 255)),
                                         is_first: ($urandom_range(0, 3) == 0),
                                         is_last: ($urandom_range(0, 3) == 0)});
         end else begin
            add_byte(jhds_pkg::MARKER_PREFIX); add_byte(jhds_pkg::SOI_CODE);
            nseg = $urandom_range(0, 3);
            repeat (nseg) begin
               do code = 8'($urandom_range(0, 255));
               while (code == jhds_pkg::SOF0_CODE || frame_code_unsupported(code));
               kind = $urandom_range(0, 99);
               if (kind < 4) seg_len = $urandom_range(0, 1);
               else if (kind < 9) seg_len = $urandom_range(256, 300);
               else seg_len = $urandom_range(2, 8);
               add_header(code, seg_len[15:0]);
               for (int i = 2; i < seg_len; i++) add_byte(8'($urandom_range(0, 255)));
            end
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
               add_header(jhds_pkg::SOF0_CODE, 16'($urandom_range(0, 65535)));
               add_byte(8'($urandom_range(0, 255)));
               repeat (2) begin
                  case ($urandom_range(0, 9))
                     0:       dim = 16'hFFFF;
                     1:       dim = 16'h0000;
                     default: dim = 16'($urandom_range(0, 65535));
                  endcase
                  add_byte(dim[15:8]);
                  add_byte(dim[7:0]);
               end
            end else if (kind < 70) begin
               do code = 8'($urandom_range(FRAME_FIRST, FRAME_LAST));
               while (!frame_code_unsupported(code));
               add_header(code, 16'($urandom_range(0, 65535)));
            end else if (kind < 80) begin
               do code = 8'($urandom_range(0, 255));
               while (code == jhds_pkg::MARKER_PREFIX);
               add_byte(code);
            end
            // trailing bytes, dropped by the scanner when they follow the outcome
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            // broken files: cut short or one byte garbled
            if ($urandom_range(0, 9) == 0) begin
               cut = $urandom_range(1, file_build.size());
               while (file_build.size() > cut) void'(file_build.pop_back());
            end
            if ($urandom_range(0, 9) == 0)
               file_build[$urandom_range(0, file_build.size() - 1)] =
                  8'($urandom_range(0, 255));
            emit_file();
         end
      end
      total_beats = pending_beats.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken != total_beats || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("jpeg_header_dimension_scanner_test: done, clean");
      end else begin
         $display("jpeg_header_dimension_scanner_test: done, errors");
      end
      $finish;
   end

endmodule
